// ===== sv/scc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	// Most columns one adjacency row can have; a run never uses more vertices.
	localparam int VERTEX_CAP = 64;
	localparam int VID_W = 6;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE_RD,
		S_EDGE_WR,
		S_P1_SCAN,
		S_P2_SCAN,
		S_P2_RD,
		S_FETCH,
		S_SRCH,
		S_STK_RD,
		S_STK_LD,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	// Commands from the sequencer to the adjacency store.
	typedef struct packed {
		logic             clear;
		logic             edge_rd;
		logic             edge_wr;
		logic             transposed;
		logic [VID_W-1:0] src;
		logic [VID_W-1:0] tgt;
		logic [VID_W-1:0] rd_vertex;
	} adj_cmd_t;

endpackage

`default_nettype wire

// ===== sv/scc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/scc_adj.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scc_adj #(
	parameter int VERTICES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scc_pkg::adj_cmd_t cmd,
	output logic [VERTICES-1:0]    rd_data
);

	import scc_pkg::*;

	localparam int VW = $clog2(VERTICES);

	logic [VERTICES-1:0] row_vld_q, col_vld_q;
	logic                row_hit_q, col_hit_q, sel_q;
	logic [VW-1:0]       row_raddr, col_raddr, src, tgt;
	logic [VERTICES-1:0] row_rdata, col_rdata, row_cur, col_cur, row_wdata, col_wdata;

	assign src = cmd.src[VW-1:0];
	assign tgt = cmd.tgt[VW-1:0];

	// Edge loads read the row of the tail and the column of the head.
	assign row_raddr = cmd.edge_rd ? src : cmd.rd_vertex[VW-1:0];
	assign col_raddr = cmd.edge_rd ? tgt : cmd.rd_vertex[VW-1:0];

	// A row never written since the last clear reads as no edges.
	assign row_cur = row_hit_q ? row_rdata : '0;
	assign col_cur = col_hit_q ? col_rdata : '0;

	assign row_wdata = row_cur | ({{(VERTICES-1){1'b0}}, 1'b1} << tgt);
	assign col_wdata = col_cur | ({{(VERTICES-1){1'b0}}, 1'b1} << src);

	assign rd_data = sel_q ? col_cur : row_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			col_vld_q <= '0;
		end else if (cmd.clear) begin
			row_vld_q <= '0;
			col_vld_q <= '0;
		end else if (cmd.edge_wr) begin
			row_vld_q[src] <= 1'b1;
			col_vld_q[tgt] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		row_hit_q <= row_vld_q[row_raddr];
		col_hit_q <= col_vld_q[col_raddr];
		sel_q     <= cmd.transposed;
	end

	scc_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_row_ram (
		.clk   (clk),
		.we    (cmd.edge_wr),
		.waddr (src),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	scc_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_col_ram (
		.clk   (clk),
		.we    (cmd.edge_wr),
		.waddr (tgt),
		.wdata (col_wdata),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

endmodule

`default_nettype wire

// ===== sv/strongly_connected_components.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Strongly connected components of a directed graph held as a bit matrix.
// Input words (item_valid/item_ready): mode add edge stores edge_source ->
// edge_target if both are below MAX_VERTICES; clear drops all edges; run
// labels vertices 0..n-1, n taken (clamped to 1..LIMIT_N) from the vertex_count
// register (cfg_write_en/cfg_write_data, write only while idle).
// A run walks the matrix with one neighbour test per cycle in both searches,
// pausing to fetch a row or pop the stack, then emits n result words
// (result_valid/result_ready), vertex 0 first; the last word carries
// component_total and last. item_ready is low throughout.
// The result word sits in an output register: a stalled receiver holds the
// emission, and the next input word is taken while the final result waits.
// Reset clears the graph (row and column flags, no sweep) and sets vertex_count to 64.
// Storage: row and column copies of the matrix, a search stack, the finish
// order and the labels, each a registered-read RAM.
module strongly_connected_components #(
	parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [1:0] mode,
	input  wire logic [5:0] edge_source,
	input  wire logic [5:0] edge_target,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [5:0]      vertex,
	output logic [5:0]      component,
	output logic [6:0]      component_total,
	output logic            last,
	input  wire logic       cfg_write_en,
	input  wire logic [6:0] cfg_write_data
);

	import scc_pkg::*;

	localparam int LIMIT_N = (MAX_VERTICES < VERTEX_CAP) ? MAX_VERTICES : VERTEX_CAP;
	localparam int VW = $clog2(LIMIT_N);
	localparam int CW = $clog2(LIMIT_N + 1);

	state_t state_q, state_d;

	logic [6:0]         vc_q;
	logic [CW-1:0]      n_q, n_calc;
	logic [VID_W-1:0]   src_q, tgt_q;
	logic [LIMIT_N-1:0] visited_q;
	logic [CW-1:0]      i_q, fcount_q, comp_cnt_q, depth_q, cur_j;
	logic [VW-1:0]      cur_v, e_q;
	logic               pass2_q;
	logic               res_valid_q, last_q;
	logic [5:0]         vertex_q, component_q;
	logic [6:0]         total_q;

	logic               accept, edge_ok, res_load, emit_done;
	logic [LIMIT_N-1:0] row, adj_rd_data;
	logic [CW-1:0]      depth_m1, fcount_m1;
	logic               at_end, take_edge;
	adj_cmd_t           adj_cmd;

	logic               stk_we, fin_we, comp_we;
	logic [VW-1:0]      stk_waddr, stk_raddr, fin_waddr, fin_raddr, comp_waddr, comp_raddr;
	logic [VW+CW-1:0]   stk_wdata, stk_rdata;
	logic [VW-1:0]      fin_wdata, fin_rdata, comp_wdata, comp_rdata;

	assign accept    = item_valid && item_ready;
	assign edge_ok   = (int'(edge_source) < MAX_VERTICES) && (int'(edge_target) < MAX_VERTICES);
	assign depth_m1  = depth_q - 1'b1;
	assign fcount_m1 = fcount_q - 1'b1;
	assign at_end    = (cur_j == n_q);
	assign take_edge = !at_end && row[cur_j[VW-1:0]] && !visited_q[cur_j[VW-1:0]];
	assign res_load  = (state_q == S_EMIT_LD) && (!res_valid_q || result_ready);
	assign emit_done = ((CW'(e_q) + CW'(1)) == n_q);

	always_comb begin
		if (vc_q == 7'd0) begin
			n_calc = CW'(1);
		end else if (vc_q > 7'(LIMIT_N)) begin
			n_calc = CW'(LIMIT_N);
		end else begin
			n_calc = vc_q[CW-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_ADD: state_d = edge_ok ? S_EDGE_RD : S_IDLE;
						MODE_RUN: state_d = S_P1_SCAN;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_EDGE_RD: state_d = S_EDGE_WR;
			S_EDGE_WR: state_d = S_IDLE;
			S_P1_SCAN: begin
				if (i_q == n_q) begin
					state_d = S_P2_SCAN;
				end else if (!visited_q[i_q[VW-1:0]]) begin
					state_d = S_FETCH;
				end
			end
			S_P2_SCAN: state_d = (fcount_q == '0) ? S_EMIT_RD : S_P2_RD;
			S_P2_RD:   state_d = visited_q[fin_rdata] ? S_P2_SCAN : S_FETCH;
			S_FETCH:   state_d = S_SRCH;
			S_SRCH: begin
				if (at_end) begin
					if (depth_q == CW'(1)) begin
						state_d = pass2_q ? S_P2_SCAN : S_P1_SCAN;
					end else begin
						state_d = S_STK_RD;
					end
				end else if (take_edge) begin
					state_d = S_FETCH;
				end
			end
			S_STK_RD:  state_d = S_STK_LD;
			S_STK_LD:  state_d = S_FETCH;
			S_EMIT_RD: state_d = S_EMIT_LD;
			S_EMIT_LD: begin
				if (res_load) begin
					state_d = emit_done ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs and memory controls
	always_comb begin
		item_ready         = (state_q == S_IDLE);
		adj_cmd.clear      = accept && (mode == MODE_CLEAR);
		adj_cmd.edge_rd    = (state_q == S_EDGE_RD);
		adj_cmd.edge_wr    = (state_q == S_EDGE_WR);
		adj_cmd.transposed = pass2_q;
		adj_cmd.src        = src_q;
		adj_cmd.tgt        = tgt_q;
		adj_cmd.rd_vertex  = VID_W'(cur_v);

		stk_we     = (state_q == S_SRCH) && take_edge;
		stk_waddr  = depth_m1[VW-1:0];
		stk_wdata  = {cur_v, CW'(cur_j + 1'b1)};
		stk_raddr  = depth_m1[VW-1:0];

		fin_we     = (state_q == S_SRCH) && at_end && !pass2_q;
		fin_waddr  = fcount_q[VW-1:0];
		fin_wdata  = cur_v;
		fin_raddr  = fcount_m1[VW-1:0];

		comp_we    = 1'b0;
		comp_waddr = cur_j[VW-1:0];
		comp_wdata = comp_cnt_q[VW-1:0];
		comp_raddr = e_q;
		if (state_q == S_P2_RD) begin
			comp_we    = !visited_q[fin_rdata];
			comp_waddr = fin_rdata;
		end else if (state_q == S_SRCH) begin
			comp_we    = take_edge && pass2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vc_q        <= 7'd64;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				vc_q <= cfg_write_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					src_q     <= edge_source;
					tgt_q     <= edge_target;
					n_q       <= n_calc;
					visited_q <= '0;
					fcount_q  <= '0;
					i_q       <= '0;
					pass2_q   <= 1'b0;
				end
			end
			S_P1_SCAN: begin
				if (i_q == n_q) begin
					pass2_q    <= 1'b1;
					visited_q  <= '0;
					comp_cnt_q <= '0;
				end else if (visited_q[i_q[VW-1:0]]) begin
					i_q <= i_q + 1'b1;
				end else begin
					visited_q[i_q[VW-1:0]] <= 1'b1;
					cur_v   <= i_q[VW-1:0];
					cur_j   <= '0;
					depth_q <= CW'(1);
				end
			end
			S_P2_SCAN: begin
				e_q <= '0;
			end
			S_P2_RD: begin
				fcount_q <= fcount_m1;
				if (!visited_q[fin_rdata]) begin
					visited_q[fin_rdata] <= 1'b1;
					cur_v   <= fin_rdata;
					cur_j   <= '0;
					depth_q <= CW'(1);
				end
			end
			S_SRCH: begin
				if (at_end) begin
					if (!pass2_q) begin
						fcount_q <= fcount_q + 1'b1;
					end
					if (depth_q == CW'(1)) begin
						if (pass2_q) begin
							comp_cnt_q <= comp_cnt_q + 1'b1;
						end
					end else begin
						depth_q <= depth_m1;
					end
				end else if (take_edge) begin
					visited_q[cur_j[VW-1:0]] <= 1'b1;
					cur_v   <= cur_j[VW-1:0];
					cur_j   <= '0;
					depth_q <= depth_q + 1'b1;
				end else begin
					cur_j <= cur_j + 1'b1;
				end
			end
			S_STK_LD: begin
				cur_v <= stk_rdata[VW+CW-1:CW];
				cur_j <= stk_rdata[CW-1:0];
			end
			S_EMIT_LD: begin
				if (res_load) begin
					vertex_q    <= 6'(e_q);
					component_q <= 6'(comp_rdata);
					total_q     <= emit_done ? 7'(comp_cnt_q) : 7'd0;
					last_q      <= emit_done;
					e_q         <= e_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign row             = adj_rd_data;
	assign result_valid    = res_valid_q;
	assign vertex          = vertex_q;
	assign component       = component_q;
	assign component_total = total_q;
	assign last            = last_q;

	scc_adj #(.VERTICES(LIMIT_N)) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (adj_cmd),
		.rd_data (adj_rd_data)
	);

	scc_ram #(.WIDTH(VW + CW), .DEPTH(LIMIT_N)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	scc_ram #(.WIDTH(VW), .DEPTH(LIMIT_N)) u_finish_ram (
		.clk   (clk),
		.we    (fin_we),
		.waddr (fin_waddr),
		.wdata (fin_wdata),
		.raddr (fin_raddr),
		.rdata (fin_rdata)
	);

	scc_ram #(.WIDTH(VW), .DEPTH(LIMIT_N)) u_label_ram (
		.clk   (clk),
		.we    (comp_we),
		.waddr (comp_waddr),
		.wdata (comp_wdata),
		.raddr (comp_raddr),
		.rdata (comp_rdata)
	);

	// Stack depth stays within the vertices of the run.
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (depth_q != '0 && depth_q <= n_q))
		else $error("search stack depth out of range");

	// The first pass finishes every vertex exactly once.
	a_finish_all: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P1_SCAN && i_q == n_q) |->
		(fcount_q == n_q && $countones(visited_q) == int'(n_q)))
		else $error("first pass did not finish every vertex");

	// The second pass labels every vertex before emission.
	a_label_all: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P2_SCAN && fcount_q == '0) |-> ($countones(visited_q) == int'(n_q)))
		else $error("second pass left vertices unlabeled");

endmodule

`default_nettype wire
